FILE: rtl/fcfl_pkg.sv
// Shared types and constants for the fixed chunk free list allocator.
// Used by fixed_chunk_free_list_allocator_top; no dependencies.
package fcfl_pkg;

    // Defaults for the top level parameters
    localparam int MAX_CHUNKS_DEF = 1024;
    localparam int WORD_BYTES_DEF = 8;

    // Field and register widths
    localparam int CB_W    = 13;   // chunk_bytes register
    localparam int CC_W    = 11;   // chunk_count register
    localparam int IDX_W   = 10;   // chunk index fields
    localparam int OFF_W   = 23;   // byte offset field
    localparam int CNT_W   = 11;   // free counter
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CB_W-1:0]  CB_RESET  = 13'd8;
    localparam logic [CC_W-1:0]  CC_RESET  = 11'd1024;
    localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic {
        REG_CHUNK_BYTES = 1'b0,
        REG_CHUNK_COUNT = 1'b1
    } t_reg_idx;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd             cmd;
        logic [IDX_W-1:0] release_index;
    } t_in_item;

    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] chunk_index;
        logic [OFF_W-1:0] byte_offset;
        logic [CNT_W-1:0] free_count;
    } t_out_item;

endpackage

FILE: rtl/fcfl_link_mem.sv
// Next-link table of the free list: one write port, one read port, registered read.
// No package dependencies; instantiated by fixed_chunk_free_list_allocator_top.
module fcfl_link_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fixed_chunk_free_list_allocator_top.sv
// Fixed chunk allocator with a LIFO free list held in a link memory.
// o_done is raised the cycle after start is taken; one item per cycle when not busy.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset and every configuration write start a relink pass that rewrites the link
// memory one entry a cycle; busy stays high meanwhile.
// Reset is synchronous, active low; depends on fcfl_pkg and fcfl_link_mem.
module fixed_chunk_free_list_allocator_top #(
    parameter int MAX_CHUNKS = fcfl_pkg::MAX_CHUNKS_DEF,
    parameter int WORD_BYTES = fcfl_pkg::WORD_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  fcfl_pkg::t_in_item                i_item,
    output logic                              o_done,
    output fcfl_pkg::t_out_item               o_result,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fcfl_pkg::PADDR_W-1:0]      paddr,
    input  logic [fcfl_pkg::PDATA_W-1:0]      pwdata,
    output logic [fcfl_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    // Address bits of the link memory and width of a link (can hold the end mark).
    localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int LW = $clog2(MAX_CHUNKS + 1);

    localparam int CB_W  = fcfl_pkg::CB_W;
    localparam int CC_W  = fcfl_pkg::CC_W;
    localparam int IDX_W = fcfl_pkg::IDX_W;
    localparam int OFF_W = fcfl_pkg::OFF_W;
    localparam int CNT_W = fcfl_pkg::CNT_W;

    // Size alignment: round chunk_bytes up to WORD_BYTES by a reciprocal multiply.
    localparam int ALX_W   = CB_W + 1;              // chunk_bytes + WORD_BYTES - 1
    localparam int RSHIFT  = 24;
    localparam int RECIP_W = RSHIFT + 1;
    localparam int MUL_W   = ALX_W + RECIP_W;
    localparam int QUOT_W  = 12;
    localparam int ALN_W   = 14;
    localparam int ALP_W   = 16;
    localparam int PROD_W  = IDX_W + ALN_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RSHIFT) + WORD_BYTES - 1) / WORD_BYTES);

    // Effective chunk count after reset
    localparam logic [CC_W-1:0] EFF_RESET =
        (int'(fcfl_pkg::CC_RESET) > MAX_CHUNKS) ? CC_W'(MAX_CHUNKS) : fcfl_pkg::CC_RESET;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    fcfl_pkg::t_state    r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [CB_W-1:0]     r_chunk_bytes, n_chunk_bytes;
    logic [CC_W-1:0]     r_chunk_count, n_chunk_count;
    logic [CC_W-1:0]     r_eff, n_eff;
    logic [LW-1:0]       r_head, n_head;
    logic [LW-1:0]       r_nxt, n_nxt;          // link of the head chunk
    logic                r_nxt_sel, n_nxt_sel;  // link of head still in the read register
    logic [CNT_W-1:0]    r_free, n_free;
    logic                r_done;
    fcfl_pkg::t_out_item r_result, n_result;
    logic [QUOT_W-1:0]   r_quot;
    logic [ALN_W-1:0]    r_aligned;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic              cfg_wr;
    fcfl_pkg::t_reg_idx cfg_idx;
    logic [CC_W-1:0]   cc_new;
    logic [CC_W-1:0]   eff_new;
    logic              accept;
    logic              is_alloc;
    logic              pop_ok;
    logic              rel_ok;
    logic [LW-1:0]     nxt;
    logic [ALX_W-1:0]  align_x;
    logic [MUL_W-1:0]  align_mul;
    logic [ALP_W-1:0]  align_prod;
    logic [PROD_W-1:0] off_prod;
    logic [PROD_W-1:0] off_sum;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [LW-1:0]     mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [LW-1:0]     mem_rdata;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = fcfl_pkg::t_reg_idx'(paddr[2]);

    always_comb begin
        case (cfg_idx)
            fcfl_pkg::REG_CHUNK_BYTES: prdata = fcfl_pkg::PDATA_W'(r_chunk_bytes);
            fcfl_pkg::REG_CHUNK_COUNT: prdata = fcfl_pkg::PDATA_W'(r_chunk_count);
            default:                   prdata = '0;
        endcase
    end

    // New count value and its clamp to 1..MAX_CHUNKS
    always_comb begin
        n_chunk_bytes = r_chunk_bytes;
        n_chunk_count = r_chunk_count;
        if (cfg_wr && cfg_idx == fcfl_pkg::REG_CHUNK_BYTES) begin
            n_chunk_bytes = pwdata[CB_W-1:0];
        end
        if (cfg_wr && cfg_idx == fcfl_pkg::REG_CHUNK_COUNT) begin
            n_chunk_count = pwdata[CC_W-1:0];
        end
        cc_new = n_chunk_count;
        if (cc_new == '0) begin
            eff_new = CC_W'(1);
        end else if (32'(cc_new) > 32'(MAX_CHUNKS)) begin
            eff_new = CC_W'(MAX_CHUNKS);
        end else begin
            eff_new = cc_new;
        end
        n_eff = eff_new;
    end

    // Aligned chunk size, two register stages; settles well within the relink pass.
    assign align_x    = ALX_W'(r_chunk_bytes) + ALX_W'(WORD_BYTES - 1);
    assign align_mul  = MUL_W'(align_x) * MUL_W'(RECIP);
    assign align_prod = ALP_W'(r_quot) * ALP_W'(WORD_BYTES);

    always_ff @(posedge i_clk) begin
        r_quot    <= align_mul[RSHIFT +: QUOT_W];
        r_aligned <= align_prod[ALN_W-1:0];
    end

    // ------------------------------------------------------------------
    // Relink sequencer: rewrite entry i with i + 1, then run
    // ------------------------------------------------------------------
    assign busy = (r_state == fcfl_pkg::ST_CLEAR);

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        case (r_state)
            fcfl_pkg::ST_CLEAR: begin
                if (r_clr == AW'(MAX_CHUNKS - 1)) begin
                    n_state = fcfl_pkg::ST_RUN;
                    n_clr   = '0;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            fcfl_pkg::ST_RUN: begin
                n_clr = '0;
            end
            default: begin
                n_state = fcfl_pkg::ST_CLEAR;
                n_clr   = '0;
            end
        endcase
        // any register write relinks the whole pool
        if (cfg_wr) begin
            n_state = fcfl_pkg::ST_CLEAR;
            n_clr   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcfl_pkg::ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // ------------------------------------------------------------------
    // Item processing: pop at the head or push onto it
    // ------------------------------------------------------------------
    assign accept   = start && !busy;
    assign is_alloc = (i_item.cmd == fcfl_pkg::CMD_ALLOC);

    // Link of the head: straight from the read register right after a pop.
    assign nxt = r_nxt_sel ? mem_rdata : r_nxt;

    assign pop_ok = is_alloc && (r_free != '0)
                    && (32'(r_head) < 32'(r_eff))
                    && (32'(r_head) < 32'(MAX_CHUNKS));
    assign rel_ok = !is_alloc && (32'(i_item.release_index) < 32'(r_eff));

    assign off_prod = PROD_W'(IDX_W'(r_head)) * PROD_W'(r_aligned);
    assign off_sum  = off_prod + PROD_W'(WORD_BYTES);

    // Memory access: relink pass owns the write port while busy.
    always_comb begin
        if (busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = LW'(r_clr) + LW'(1);
        end else begin
            mem_we    = accept && rel_ok;
            mem_waddr = AW'(i_item.release_index);
            mem_wdata = r_head;
        end
        // fetch the link of the new head so the next pop finds it ready
        mem_re    = accept && pop_ok;
        mem_raddr = (32'(nxt) < 32'(MAX_CHUNKS)) ? AW'(nxt) : '0;
    end

    always_comb begin
        n_head    = r_head;
        n_nxt     = nxt;
        n_nxt_sel = 1'b0;
        n_free    = r_free;
        if (accept && pop_ok) begin
            n_head    = nxt;
            n_nxt_sel = 1'b1;
            n_free    = r_free - CNT_W'(1);
        end else if (accept && rel_ok) begin
            n_head = LW'(i_item.release_index);
            n_nxt  = r_head;
            if (r_free < fcfl_pkg::COUNT_MAX) begin
                n_free = r_free + CNT_W'(1);
            end
        end
        if (cfg_wr) begin
            n_head    = '0;
            n_nxt     = LW'(1);
            n_nxt_sel = 1'b0;
            n_free    = CNT_W'(eff_new);
        end

        n_result.granted     = pop_ok || rel_ok;
        n_result.chunk_index = pop_ok ? IDX_W'(r_head) : '0;
        n_result.byte_offset = pop_ok ? off_sum[OFF_W-1:0] : '0;
        n_result.free_count  = n_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_bytes <= fcfl_pkg::CB_RESET;
            r_chunk_count <= fcfl_pkg::CC_RESET;
            r_eff         <= EFF_RESET;
            r_head        <= '0;
            r_nxt         <= LW'(1);
            r_nxt_sel     <= 1'b0;
            r_free        <= CNT_W'(EFF_RESET);
            r_done        <= 1'b0;
        end else begin
            r_chunk_bytes <= n_chunk_bytes;
            r_chunk_count <= n_chunk_count;
            r_eff         <= n_eff;
            r_head        <= n_head;
            r_nxt         <= n_nxt;
            r_nxt_sel     <= n_nxt_sel;
            r_free        <= n_free;
            r_done        <= accept;
        end
    end

    // Hold the result payload only when an item is taken.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    fcfl_link_mem #(
        .DEPTH (MAX_CHUNKS),
        .AW    (AW),
        .DW    (LW)
    ) u_link_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("accepted item produced no result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result without an accepted item");

    a_cfg_relinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) |=> (busy && r_head == '0 && r_free == CNT_W'(r_eff)))
        else $error("configuration write did not restart the relink pass");

    a_empty_refuses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd == fcfl_pkg::CMD_ALLOC && r_free == '0)
        |=> (o_done && !o_result.granted && o_result.free_count == '0))
        else $error("allocate from an empty pool was granted");

endmodule
